>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the triplet loss block.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define TEL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tel assertion failed");
// Condition that must never be true outside reset.
`define TEL_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tel forbidden condition");
`else
`define TEL_ASSERT(label, prop)
`define TEL_NEVER(label, cond)
`endif
`endif

>>> hw/rtl/tel_pkg.sv
// Types and constants of the triplet exponential loss block.
// No dependencies.
`timescale 1ns / 1ps
package tel_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_MARGIN     = 1'b0;
  localparam logic REG_USE_WEIGHT = 1'b1;

  localparam logic [15:0] MARGIN_RESET = 16'd256;
  localparam logic [23:0] LN2_Q24      = 24'd11629080;
  localparam logic [49:0] EXP_LIMIT    = 50'd285212672;
  localparam logic [47:0] SAT48        = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] SAT32        = 32'hFFFF_FFFF;
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [15:0] WEIGHT_ONE   = 16'd256;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

  typedef struct packed {
    logic signed [15:0] anchor_value;
    logic signed [15:0] positive_value;
    logic signed [15:0] negative_value;
    logic [15:0]        sample_weight;
    logic               last_channel;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sample_loss;
    logic [31:0] batch_loss;
    logic        batch_done;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic square;
    logic accum;
    logic hinge;
    logic reduce_step;
    logic exp_init;
    logic exp_mul;
    logic div_start_exp;
    logic exp_take;
    logic scale;
    logic weight;
    logic sum;
    logic div_start_mean;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_channel;
    logic last_sample;
    logic big;
    logic reduce_more;
    logic exp_last;
    logic div_idle;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/tel_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Shared by the Taylor series terms and the batch mean; no package use.
`timescale 1ns / 1ps
module tel_div #(
  parameter int NW = 48,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem;
  logic [DW-1:0]   div_reg;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     rem_sh;
  logic            ge;

  // One shift-and-subtract step.
  assign rem_sh = {rem, quotient[NW-1]};
  assign ge     = rem_sh >= {1'b0, div_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      cnt      <= CNTW'(NW);
      rem      <= '0;
      div_reg  <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? DW'(rem_sh - {1'b0, div_reg}) : rem_sh[DW-1:0];
      quotient <= {quotient[NW-2:0], ge};
      cnt      <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

>>> hw/rtl/tel_datapath.sv
// Datapath: distance sums, hinge, exponential, weighting and batch mean.
// Depends on tel_pkg and tel_div.
`timescale 1ns / 1ps
module tel_datapath #(
  parameter int MAX_BATCH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  tel_pkg::cmd_t     cmd,
  output tel_pkg::sts_t     sts,
  input  tel_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tel_pkg::out_item_t out_data
);
  import tel_pkg::*;

  localparam int CW   = $clog2(MAX_BATCH + 1);
  localparam int DIVW = (CW > 4) ? CW : 4;

  logic signed [15:0] margin;
  logic               use_weight;
  in_item_t           item;
  logic [32:0]        sq_ap, sq_an, sq_pn;
  logic [47:0]        dap, dan, dpn;
  logic [47:0]        loss_sum;
  logic [CW-1:0]      sample_count;
  logic               big;
  logic [28:0]        r;
  logic [4:0]         k;
  logic [30:0]        term;
  logic [31:0]        exp_sum;
  logic [30:0]        prod;
  logic [3:0]         idx;
  logic [40:0]        em1;
  logic [31:0]        sample_term;

  logic signed [16:0] d_ap, d_an, d_pn;
  logic signed [33:0] p_ap, p_an, p_pn;
  logic [48:0]        s_ap, s_an, s_pn, s_loss;
  logic signed [50:0] mq, m1, m2;
  logic [49:0]        m1c, m2c;
  logic [50:0]        msum;
  logic [49:0]        y;
  logic [60:0]        mul_full;
  logic [55:0]        e_shift;
  logic [40:0]        e_val;
  logic [56:0]        wprod;
  logic [48:0]        wshift;
  logic [15:0]        w_eff;
  logic               div_start;
  logic [47:0]        div_dividend;
  logic [DIVW-1:0]    div_divisor;
  logic               div_busy;
  logic               div_done;
  logic [47:0]        div_quo;

  // Squared differences of the captured channel element.
  assign d_ap = 17'(item.anchor_value) - 17'(item.positive_value);
  assign d_an = 17'(item.anchor_value) - 17'(item.negative_value);
  assign d_pn = 17'(item.positive_value) - 17'(item.negative_value);
  assign p_ap = d_ap * d_ap;
  assign p_an = d_an * d_an;
  assign p_pn = d_pn * d_pn;

  // Saturating distance accumulation.
  assign s_ap = {1'b0, dap} + 49'(sq_ap);
  assign s_an = {1'b0, dan} + 49'(sq_an);
  assign s_pn = {1'b0, dpn} + 49'(sq_pn);

  // Hinge terms in Q.24 and their halved sum.
  assign mq   = {{19{margin[15]}}, margin, 16'b0};
  assign m1   = mq + $signed({3'b0, dap}) - $signed({3'b0, dan});
  assign m2   = mq + $signed({3'b0, dap}) - $signed({3'b0, dpn});
  assign m1c  = m1[50] ? '0 : m1[49:0];
  assign m2c  = m2[50] ? '0 : m2[49:0];
  assign msum = {1'b0, m1c} + {1'b0, m2c};
  assign y    = msum[50:1];

  // Taylor term product, scaling by 2^k and weighting.
  assign mul_full = 61'(term) * 61'({r[23:0], 6'b0});
  assign e_shift  = 56'(exp_sum) << k;
  assign e_val    = e_shift[54:14];
  assign w_eff    = use_weight ? item.sample_weight : WEIGHT_ONE;
  assign wprod    = 57'(em1) * 57'(w_eff);
  assign wshift   = wprod[56:8];
  assign s_loss   = {1'b0, loss_sum} + 49'(sample_term);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      margin     <= $signed(MARGIN_RESET);
      use_weight <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MARGIN:     margin     <= $signed(cfg_data);
        REG_USE_WEIGHT: use_weight <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Sample and batch state.
  always_ff @(posedge clk) begin
    if (rst) begin
      dap          <= '0;
      dan          <= '0;
      dpn          <= '0;
      loss_sum     <= '0;
      sample_count <= '0;
    end else begin
      if (cmd.accum) begin
        dap <= s_ap[48] ? SAT48 : s_ap[47:0];
        dan <= s_an[48] ? SAT48 : s_an[47:0];
        dpn <= s_pn[48] ? SAT48 : s_pn[47:0];
      end
      if (cmd.sum) begin
        dap      <= '0;
        dan      <= '0;
        dpn      <= '0;
        loss_sum <= s_loss[48] ? SAT48 : s_loss[47:0];
        if (sample_count < CW'(MAX_BATCH)) begin
          sample_count <= sample_count + 1'b1;
        end
      end
      if (cmd.out_load && item.last_sample) begin
        loss_sum     <= '0;
        sample_count <= '0;
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_data;
    if (cmd.square) begin
      sq_ap <= p_ap[32:0];
      sq_an <= p_an[32:0];
      sq_pn <= p_pn[32:0];
    end
    if (cmd.hinge) begin
      big <= y >= EXP_LIMIT;
      r   <= y[28:0];
      k   <= '0;
    end
    if (cmd.reduce_step) begin
      r <= r - 29'(LN2_Q24);
      k <= k + 1'b1;
    end
    if (cmd.exp_init) begin
      term    <= 31'h4000_0000;
      exp_sum <= 32'h4000_0000;
      idx     <= 4'd1;
    end
    if (cmd.exp_mul) prod <= mul_full[60:30];
    if (cmd.exp_take) begin
      term    <= div_quo[30:0];
      exp_sum <= exp_sum + 32'(div_quo[30:0]);
      idx     <= idx + 1'b1;
    end
    if (cmd.scale) em1 <= (e_val > 41'(ONE_Q16)) ? e_val - 41'(ONE_Q16) : '0;
    if (cmd.weight) begin
      if (big) sample_term <= (w_eff == '0) ? '0 : SAT32;
      else     sample_term <= (wshift > 49'(SAT32)) ? SAT32 : wshift[31:0];
    end
  end

  // Shared divider.
  assign div_start    = cmd.div_start_exp || cmd.div_start_mean;
  assign div_dividend = cmd.div_start_exp ? 48'(prod) : loss_sum;
  assign div_divisor  = cmd.div_start_exp ? DIVW'(idx) : DIVW'(sample_count);

  tel_div #(.NW(48), .DW(DIVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data.sample_loss <= sample_term;
      out_data.batch_done  <= item.last_sample;
      if (item.last_sample) begin
        out_data.batch_loss <= (div_quo > 48'(SAT32)) ? SAT32 : div_quo[31:0];
      end else begin
        out_data.batch_loss <= '0;
      end
    end
  end

  // Status toward the controller.
  assign sts.last_channel = item.last_channel;
  assign sts.last_sample  = item.last_sample;
  assign sts.big          = big;
  assign sts.reduce_more  = r >= 29'(LN2_Q24);
  assign sts.exp_last     = idx == TAYLOR_TERMS;
  assign sts.div_idle     = !div_busy;
  assign sts.div_done     = div_done;
  assign sts.out_free     = !out_valid || !out_stall;
endmodule

>>> hw/rtl/tel_ctrl.sv
// Controller state machine sequencing the datapath for one request at a time.
// Depends on tel_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tel_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tel_pkg::sts_t sts,
  output tel_pkg::cmd_t cmd
);
  import tel_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_HINGE = 4'd3;
  localparam logic [3:0] S_RED   = 4'd4;
  localparam logic [3:0] S_EMUL  = 4'd5;
  localparam logic [3:0] S_EDIVS = 4'd6;
  localparam logic [3:0] S_EDIVW = 4'd7;
  localparam logic [3:0] S_SCALE = 4'd8;
  localparam logic [3:0] S_WGT   = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;
  localparam logic [3:0] S_MDIVS = 4'd11;
  localparam logic [3:0] S_MDIVW = 4'd12;
  localparam logic [3:0] S_OUTW  = 4'd13;

  logic [3:0] state, state_next;

  assign in_stall = state != S_IDLE;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.accum  = 1'b1;
        state_next = sts.last_channel ? S_HINGE : S_IDLE;
      end
      S_HINGE: begin
        cmd.hinge  = 1'b1;
        state_next = S_RED;
      end
      S_RED: begin
        if (sts.big) begin
          state_next = S_WGT;
        end else if (sts.reduce_more) begin
          cmd.reduce_step = 1'b1;
        end else begin
          cmd.exp_init = 1'b1;
          state_next   = S_EMUL;
        end
      end
      S_EMUL: begin
        cmd.exp_mul = 1'b1;
        state_next  = S_EDIVS;
      end
      S_EDIVS: begin
        cmd.div_start_exp = 1'b1;
        state_next        = S_EDIVW;
      end
      S_EDIVW: begin
        if (sts.div_done) begin
          cmd.exp_take = 1'b1;
          state_next   = sts.exp_last ? S_SCALE : S_EMUL;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_WGT;
      end
      S_WGT: begin
        cmd.weight = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = sts.last_sample ? S_MDIVS : S_OUTW;
      end
      S_MDIVS: begin
        cmd.div_start_mean = 1'b1;
        state_next         = S_MDIVW;
      end
      S_MDIVW: begin
        if (sts.div_done) state_next = S_OUTW;
      end
      S_OUTW: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `TEL_ASSERT(a_accept_to_square, (in_valid && !in_stall) |=> (state == S_SQ))
  `TEL_NEVER(a_load_blocked, cmd.out_load && !sts.out_free)
  `TEL_NEVER(a_div_overlap, (cmd.div_start_exp || cmd.div_start_mean) && !sts.div_idle)
endmodule

>>> hw/rtl/triplet_exp_loss_forward.sv
// Channel  | Direction | Handshake          | Payload
// in       | input     | in_valid/in_stall  | in_data (anchor, positive, negative, weight, marks)
// out      | output    | out_valid/out_stall| out_data (sample_loss, batch_loss, batch_done)
// cfg      | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// A channel element that is not the last of its sample is captured, squared and accumulated.
// The last element of a sample also runs the hinge and, unless it is too big, range reduction
// and a 12-term Taylor series in the shared serial divider, plus the batch mean at batch end.
// Reset is synchronous and clears the distance and loss sums, the sample counter and configuration to defaults.
// A stalled result waits in the output register while the next element is accepted.
// Top level of the triplet exponential loss forward block; depends on tel_pkg,
// tel_ctrl and tel_datapath.
`timescale 1ns / 1ps
module triplet_exp_loss_forward #(
  parameter int MAX_BATCH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tel_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tel_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import tel_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tel_datapath #(.MAX_BATCH(MAX_BATCH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule
